### rtl/urnhist_pkg.sv
// shared types and constants for the urn model step histogram block
package urnhist_pkg;

  // default sizes handed to the top level
  localparam int MAX_PARTICLES_DEF = 64;
  localparam int COUNTER_BITS_DEF  = 32;

  // fixed field widths
  localparam int ONES_W = 7;
  localparam int PART_W = 6;
  localparam int BIN_W  = 7;
  localparam int OUT_W  = 32;

  // smallest particle count the register accepts
  localparam logic [ONES_W-1:0] PC_MIN = 7'd2;

  // result queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // item modes
  localparam logic MODE_STEP = 1'b0;
  localparam logic MODE_READ = 1'b1;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_COUNT,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic              mode;
    logic [PART_W-1:0] particle;
    logic [BIN_W-1:0]  bin;
  } in_t;

  typedef struct packed {
    logic [ONES_W-1:0] ones_count;
    logic [OUT_W-1:0]  step_number;
    logic [OUT_W-1:0]  equilibrium_step;
    logic [OUT_W-1:0]  recurrence_step;
    logic              finished;
    logic [OUT_W-1:0]  bin_value;
    logic              bad_index;
  } out_t;

endpackage

### rtl/urnhist_ram.sv
// generic single-port-write, single-port-read ram with registered read data
module urnhist_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, old data on a same-address write
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### rtl/urn_model_step_histogram.sv
// urn model step with occupancy histogram: top level
//
//   channel   | signals                      | moves
//   ----------+------------------------------+-------------------------------
//   in        | in_valid, in_ready, in_data  | step or histogram read request
//   out       | out_valid, out_ready, out_data | one result per request
//   cfg       | cfg_wr_en, cfg_wr_data       | particle_count write, no wait
//
// one transaction per cycle while in_ready is high; results pass stage 1 and stage 2
// the rate is set by the histogram ram read-modify-write, forwarded one deep
// after reset a clearing pass fills the rams, in_ready low
// a particle_count write after the clearing pass starts a recount, in_ready low
// a 4-deep result queue lets in move while out stalls, until queue and stages hold 4
module urn_model_step_histogram #(
  parameter int MAX_PARTICLES = urnhist_pkg::MAX_PARTICLES_DEF,
  parameter int COUNTER_BITS  = urnhist_pkg::COUNTER_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  urnhist_pkg::in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output urnhist_pkg::out_t               out_data,
  input  logic                            cfg_wr_en,
  input  logic [urnhist_pkg::ONES_W-1:0]  cfg_wr_data
);

  localparam int PA_W   = $clog2(MAX_PARTICLES);
  localparam int HDEPTH = MAX_PARTICLES + 1;
  localparam int HA_W   = $clog2(HDEPTH);
  localparam int OW     = urnhist_pkg::ONES_W;
  localparam int PC_MAX = (MAX_PARTICLES > (2**OW - 1)) ? (2**OW - 1) : MAX_PARTICLES;
  localparam int CB     = COUNTER_BITS;

  // saturating increment
  function automatic logic [CB-1:0] sat_inc(input logic [CB-1:0] v);
    return (&v) ? v : v + CB'(1);
  endfunction

  // counter value shown on a 32-bit field, all ones when it does not fit
  function automatic logic [urnhist_pkg::OUT_W-1:0] clip(input logic [CB-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    if (w > 64'h0000_0000_FFFF_FFFF) begin
      return '1;
    end
    return w[urnhist_pkg::OUT_W-1:0];
  endfunction

  urnhist_pkg::state_t state, state_next;

  logic [HA_W-1:0] init_addr;
  logic [PA_W:0]   sweep;
  logic            sweep_pend;
  logic [OW-1:0]   acc;
  logic            sweep_lt;
  logic            count_done;

  logic [OW-1:0]   pc;
  logic [OW-1:0]   cfg_val;
  logic [OW-1:0]   ones;
  logic [CB-1:0]   step_cnt;
  logic [CB-1:0]   eq_step;
  logic [CB-1:0]   rec_step;

  // particle ram ports
  logic            p_we;
  logic [PA_W-1:0] p_waddr;
  logic            p_wdata;
  logic [PA_W-1:0] p_raddr;
  logic            p_rdata;
  logic [PA_W-1:0] in_paddr;
  logic [31:0]     in_part_ext;

  // histogram ram ports
  logic            h_we;
  logic [HA_W-1:0] h_waddr;
  logic [CB-1:0]   h_wdata;
  logic [HA_W-1:0] h_raddr;
  logic [CB-1:0]   h_rdata;

  // stage 1
  logic              s1_valid;
  urnhist_pkg::in_t  s1_item;
  logic [PA_W-1:0]   s1_paddr;
  logic              s1_is_step;
  logic              s1_bad;
  logic              s1_step_ok;
  logic              done_cur;
  logic              bit_old;
  logic [OW-1:0]     ones_new;
  logic [CB-1:0]     step_new;
  logic [CB-1:0]     eq_new;
  logic [CB-1:0]     rec_new;
  logic [OW-1:0]     ones_out;
  logic [CB-1:0]     step_out;
  logic [CB-1:0]     eq_out;
  logic [CB-1:0]     rec_out;
  urnhist_pkg::out_t s1_res;
  logic [HA_W-1:0]   s1_haddr;
  logic [31:0]       s1_hsel;

  // last particle write, for forwarding
  logic              pw_valid;
  logic [PA_W-1:0]   pw_addr;
  logic              pw_data;

  // stage 2
  logic              s2_valid;
  logic              s2_inc;
  logic              s2_rd;
  logic [HA_W-1:0]   s2_haddr;
  urnhist_pkg::out_t s2_res;
  urnhist_pkg::out_t s2_out;
  logic [CB-1:0]     h_old;
  logic [CB-1:0]     h_new;

  // last histogram write, for forwarding
  logic              hw_valid;
  logic [HA_W-1:0]   hw_addr;
  logic [CB-1:0]     hw_data;

  // result queue
  urnhist_pkg::out_t                fifo_mem [urnhist_pkg::FIFO_DEPTH];
  logic [urnhist_pkg::FIFO_AW-1:0]  wr_ptr;
  logic [urnhist_pkg::FIFO_AW-1:0]  rd_ptr;
  logic [urnhist_pkg::FIFO_CW-1:0]  fifo_cnt;
  logic [urnhist_pkg::FIFO_CW-1:0]  in_flight;
  logic                             push;
  logic                             pop;
  logic                             accept;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= urnhist_pkg::ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  // clearing pass, recount and run
  always_comb begin
    state_next = state;
    unique case (state)
      urnhist_pkg::ST_INIT: begin
        if (init_addr == HA_W'(MAX_PARTICLES)) begin
          state_next = urnhist_pkg::ST_RUN;
        end
      end
      urnhist_pkg::ST_RUN: begin
        if (cfg_wr_en) begin
          state_next = urnhist_pkg::ST_COUNT;
        end
      end
      urnhist_pkg::ST_COUNT: begin
        if (!cfg_wr_en && count_done) begin
          state_next = urnhist_pkg::ST_RUN;
        end
      end
      default: state_next = urnhist_pkg::ST_INIT;
    endcase
  end

  // clamp the written particle count
  always_comb begin
    if (cfg_wr_data < urnhist_pkg::PC_MIN) begin
      cfg_val = urnhist_pkg::PC_MIN;
    end else if (32'(cfg_wr_data) > 32'(PC_MAX)) begin
      cfg_val = OW'(PC_MAX);
    end else begin
      cfg_val = cfg_wr_data;
    end
  end

  // clearing pass address
  always_ff @(posedge clk) begin
    if (rst) begin
      init_addr <= '0;
    end else if (state == urnhist_pkg::ST_INIT) begin
      init_addr <= init_addr + HA_W'(1);
    end
  end

  // recount sweep over particles 0..pc-1
  assign sweep_lt   = 32'(sweep) < 32'(pc);
  assign count_done = (state == urnhist_pkg::ST_COUNT) && !sweep_lt && !sweep_pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep      <= '0;
      sweep_pend <= 1'b0;
      acc        <= '0;
    end else if (cfg_wr_en && state != urnhist_pkg::ST_INIT) begin
      sweep      <= '0;
      sweep_pend <= 1'b0;
      acc        <= '0;
    end else if (state == urnhist_pkg::ST_COUNT) begin
      sweep_pend <= sweep_lt;
      if (sweep_lt) begin
        sweep <= sweep + (PA_W+1)'(1);
      end
      if (sweep_pend) begin
        acc <= acc + OW'(p_rdata);
      end
    end
  end

  // particle ram: all ones in the clearing pass, flips in stage 1
  assign in_part_ext = 32'(in_data.particle);
  assign in_paddr    = in_part_ext[PA_W-1:0];

  always_comb begin
    if (state == urnhist_pkg::ST_INIT) begin
      p_we    = 32'(init_addr) < 32'(MAX_PARTICLES);
      p_waddr = init_addr[PA_W-1:0];
      p_wdata = 1'b1;
    end else begin
      p_we    = s1_step_ok;
      p_waddr = s1_paddr;
      p_wdata = ~bit_old;
    end
    p_raddr = (state == urnhist_pkg::ST_COUNT) ? sweep[PA_W-1:0] : in_paddr;
  end

  urnhist_ram #(
    .WIDTH (1),
    .DEPTH (MAX_PARTICLES)
  ) u_particle_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  // histogram ram: zero in the clearing pass, increments in stage 2
  always_comb begin
    if (state == urnhist_pkg::ST_INIT) begin
      h_we    = 1'b1;
      h_waddr = init_addr;
      h_wdata = '0;
    end else begin
      h_we    = s2_valid && s2_inc;
      h_waddr = s2_haddr;
      h_wdata = h_new;
    end
    h_raddr = s1_haddr;
  end

  urnhist_ram #(
    .WIDTH (CB),
    .DEPTH (HDEPTH)
  ) u_hist_ram (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  // input handshake
  assign in_flight = urnhist_pkg::FIFO_CW'(s1_valid) + urnhist_pkg::FIFO_CW'(s2_valid);
  assign in_ready  = (state == urnhist_pkg::ST_RUN) &&
                     ((fifo_cnt + in_flight) < urnhist_pkg::FIFO_CW'(urnhist_pkg::FIFO_DEPTH));
  assign accept    = in_valid && in_ready;

  // stage 1 register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_item  <= in_data;
    s1_paddr <= in_paddr;
  end

  // stage 1: flip, count, latch
  always_comb begin
    s1_is_step = s1_item.mode == urnhist_pkg::MODE_STEP;
    if (s1_is_step) begin
      s1_bad = {1'b0, s1_item.particle} >= pc;
    end else begin
      s1_bad = s1_item.bin > pc;
    end
    done_cur   = (eq_step != '0) && (rec_step != '0);
    s1_step_ok = s1_valid && s1_is_step && !s1_bad && !done_cur;

    bit_old  = (pw_valid && pw_addr == s1_paddr) ? pw_data : p_rdata;
    ones_new = bit_old ? ones - OW'(1) : ones + OW'(1);
    step_new = sat_inc(step_cnt);
    eq_new   = (eq_step == '0 && ones_new == (pc >> 1)) ? step_new : eq_step;
    rec_new  = (rec_step == '0 && ones_new == pc) ? step_new : rec_step;

    ones_out = s1_step_ok ? ones_new : ones;
    step_out = s1_step_ok ? step_new : step_cnt;
    eq_out   = s1_step_ok ? eq_new : eq_step;
    rec_out  = s1_step_ok ? rec_new : rec_step;

    s1_res.ones_count       = ones_out;
    s1_res.step_number      = clip(step_out);
    s1_res.equilibrium_step = clip(eq_out);
    s1_res.recurrence_step  = clip(rec_out);
    s1_res.finished         = (eq_out != '0) && (rec_out != '0);
    s1_res.bin_value        = '0;
    s1_res.bad_index        = s1_bad;

    s1_hsel  = s1_is_step ? 32'(ones_new) : 32'(s1_item.bin);
    s1_haddr = s1_hsel[HA_W-1:0];
  end

  // scalar state
  always_ff @(posedge clk) begin
    if (rst) begin
      pc       <= OW'(PC_MAX);
      ones     <= OW'(PC_MAX);
      step_cnt <= '0;
      eq_step  <= '0;
      rec_step <= '0;
    end else begin
      if (cfg_wr_en) begin
        pc <= cfg_val;
      end
      if (cfg_wr_en && state == urnhist_pkg::ST_INIT) begin
        ones <= cfg_val;
      end else if (!cfg_wr_en && count_done) begin
        ones <= acc;
      end else if (s1_step_ok) begin
        ones <= ones_new;
      end
      if (s1_step_ok) begin
        step_cnt <= step_new;
        eq_step  <= eq_new;
        rec_step <= rec_new;
      end
    end
  end

  // particle write forwarding
  always_ff @(posedge clk) begin
    if (rst) begin
      pw_valid <= 1'b0;
    end else begin
      pw_valid <= s1_step_ok;
    end
  end

  always_ff @(posedge clk) begin
    pw_addr <= s1_paddr;
    pw_data <= ~bit_old;
  end

  // stage 2 register
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_inc   <= s1_step_ok;
    s2_rd    <= !s1_is_step && !s1_bad;
    s2_haddr <= s1_haddr;
    s2_res   <= s1_res;
  end

  // stage 2: histogram read-modify-write
  always_comb begin
    h_old  = (hw_valid && hw_addr == s2_haddr) ? hw_data : h_rdata;
    h_new  = sat_inc(h_old);
    s2_out = s2_res;
    s2_out.bin_value = s2_rd ? clip(h_old) : '0;
  end

  // histogram write forwarding
  always_ff @(posedge clk) begin
    if (rst) begin
      hw_valid <= 1'b0;
    end else begin
      hw_valid <= s2_valid && s2_inc;
    end
  end

  always_ff @(posedge clk) begin
    hw_addr <= s2_haddr;
    hw_data <= h_new;
  end

  // result queue
  assign push      = s2_valid;
  assign pop       = out_valid && out_ready;
  assign out_valid = fifo_cnt != '0;
  assign out_data  = fifo_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      fifo_cnt <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + urnhist_pkg::FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + urnhist_pkg::FIFO_AW'(1);
      end
      if (push && !pop) begin
        fifo_cnt <= fifo_cnt + urnhist_pkg::FIFO_CW'(1);
      end else if (pop && !push) begin
        fifo_cnt <= fifo_cnt - urnhist_pkg::FIFO_CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr] <= s2_out;
    end
  end

endmodule

### rtl/urnhist_chk.sv
// port-level checker for the urn model step histogram block, with its bind
module urnhist_chk (
  input logic              clk,
  input logic              rst,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input urnhist_pkg::out_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // the clearing pass keeps the input closed right after reset
  a_init_closed: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("input open during clearing pass");

  // finished only with both steps latched
  a_finished: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.finished |->
      out_data.equilibrium_step != '0 && out_data.recurrence_step != '0)
    else $error("finished without both latched steps");

  // latched steps never lie ahead of the step count
  a_latch_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.equilibrium_step <= out_data.step_number &&
                  out_data.recurrence_step <= out_data.step_number)
    else $error("latched step beyond step count");

  // a rejected index returns no histogram data
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.bad_index |-> out_data.bin_value == '0)
    else $error("bin value on a bad index");

endmodule

bind urn_model_step_histogram urnhist_chk u_urnhist_chk (.*);

### bench/testbench.sv
// self-checking testbench for the urn model step histogram block
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import urnhist_pkg::*;

  localparam logic [ONES_W-1:0] PC_MAX = 7'(MAX_PARTICLES_DEF);

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [ONES_W-1:0] cfg_value;
    in_t               item;
    logic              fixed;
    out_t              want;
  } row_t;

  // directed rows; fixed rows carry their result, the rest use the predictor
  localparam int ROWS = 27;
  localparam row_t DIRECTED [ROWS] = '{
    '{ROW_ITEM, 7'd0, '{MODE_READ, 6'd0, 7'd0}, 1'b1,
      '{7'd64, 32'd0, 32'd0, 32'd0, 1'b0, 32'd0, 1'b0}},
    '{ROW_ITEM, 7'd0, '{MODE_READ, 6'd63, 7'd64}, 1'b1,
      '{7'd64, 32'd0, 32'd0, 32'd0, 1'b0, 32'd0, 1'b0}},
    '{ROW_ITEM, 7'd0, '{MODE_READ, 6'd0, 7'd127}, 1'b1,
      '{7'd64, 32'd0, 32'd0, 32'd0, 1'b0, 32'd0, 1'b1}},
    '{ROW_ITEM, 7'd0, '{MODE_READ, 6'd0, 7'd65}, 1'b1,
      '{7'd64, 32'd0, 32'd0, 32'd0, 1'b0, 32'd0, 1'b1}},
    '{ROW_ITEM, 7'd0, '{MODE_STEP, 6'd0, 7'd0}, 1'b1,
      '{7'd63, 32'd1, 32'd0, 32'd0, 1'b0, 32'd0, 1'b0}},
    '{ROW_ITEM, 7'd0, '{MODE_STEP, 6'd0, 7'd0}, 1'b1,
      '{7'd64, 32'd2, 32'd0, 32'd2, 1'b0, 32'd0, 1'b0}},
    '{ROW_ITEM, 7'd0, '{MODE_READ, 6'd0, 7'd63}, 1'b1,
      '{7'd64, 32'd2, 32'd0, 32'd2, 1'b0, 32'd1, 1'b0}},
    '{ROW_ITEM, 7'd0, '{MODE_STEP, 6'd63, 7'd0}, 1'b0, '0},
    '{ROW_ITEM, 7'd0, '{MODE_STEP, 6'd42, 7'd127}, 1'b0, '0},
    '{ROW_CFG, 7'd0, '0, 1'b0, '0},
    '{ROW_ITEM, 7'd0, '{MODE_STEP, 6'd2, 7'd0}, 1'b0, '0},
    '{ROW_ITEM, 7'd0, '{MODE_STEP, 6'd63, 7'd0}, 1'b0, '0},
    '{ROW_ITEM, 7'd0, '{MODE_READ, 6'd0, 7'd2}, 1'b0, '0},
    '{ROW_ITEM, 7'd0, '{MODE_READ, 6'd0, 7'd3}, 1'b0, '0},
    '{ROW_CFG, 7'd127, '0, 1'b0, '0},
    '{ROW_ITEM, 7'd0, '{MODE_STEP, 6'd63, 7'd0}, 1'b0, '0},
    '{ROW_ITEM, 7'd0, '{MODE_STEP, 6'd42, 7'd0}, 1'b0, '0},
    '{ROW_CFG, 7'd1, '0, 1'b0, '0},
    '{ROW_CFG, 7'd65, '0, 1'b0, '0},
    '{ROW_ITEM, 7'd0, '{MODE_STEP, 6'd21, 7'd0}, 1'b0, '0},
    '{ROW_CFG, 7'd33, '0, 1'b0, '0},
    '{ROW_ITEM, 7'd0, '{MODE_STEP, 6'd32, 7'd0}, 1'b0, '0},
    '{ROW_ITEM, 7'd0, '{MODE_STEP, 6'd33, 7'd0}, 1'b0, '0},
    '{ROW_ITEM, 7'd0, '{MODE_READ, 6'd0, 7'd33}, 1'b0, '0},
    '{ROW_ITEM, 7'd0, '{MODE_READ, 6'd0, 7'd34}, 1'b0, '0},
    '{ROW_ITEM, 7'd0, '{MODE_READ, 6'd0, 7'd31}, 1'b0, '0},
    '{ROW_CFG, 7'd64, '0, 1'b0, '0}
  };

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  in_t               in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_t              out_data;
  logic              cfg_wr_en = 1'b0;
  logic [ONES_W-1:0] cfg_wr_data = '0;

  // predicted urn state
  logic [MAX_PARTICLES_DEF-1:0] urn_bits;
  logic [ONES_W-1:0]            urn_size;
  logic [ONES_W-1:0]            urn_ones;
  logic [OUT_W-1:0]             occupancy [MAX_PARTICLES_DEF+1];
  logic [OUT_W-1:0]             steps_taken;
  logic [OUT_W-1:0]             equilibrium_at;
  logic [OUT_W-1:0]             recurrence_at;

  out_t        results_due [$];
  int          fail_count = 0;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned hold_left = 0;

  always #5 clk = ~clk;

  urn_model_step_histogram DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // register write: clamp the particle count and recount ones in use
  function automatic void load_particle_count(input logic [ONES_W-1:0] value);
    int i;
    if (value < PC_MIN) begin
      urn_size = PC_MIN;
    end else if (value > PC_MAX) begin
      urn_size = PC_MAX;
    end else begin
      urn_size = value;
    end
    urn_ones = '0;
    for (i = 0; i < MAX_PARTICLES_DEF; i++) begin
      if (i < urn_size) begin
        urn_ones = urn_ones + urn_bits[i];
      end
    end
  endfunction

  // one step or histogram read, returns the result it should produce
  function automatic out_t advance_urn(input in_t it);
    out_t r;
    r = '0;
    if (it.mode == MODE_STEP) begin
      if (7'(it.particle) >= urn_size) begin
        r.bad_index = 1'b1;
      end else if (equilibrium_at == 0 || recurrence_at == 0) begin
        urn_bits[it.particle] = ~urn_bits[it.particle];
        urn_ones = urn_bits[it.particle] ? urn_ones + 7'd1 : urn_ones - 7'd1;
        if (steps_taken != '1) begin
          steps_taken = steps_taken + 1;
        end
        if (occupancy[urn_ones] != '1) begin
          occupancy[urn_ones] = occupancy[urn_ones] + 1;
        end
        if (equilibrium_at == 0 && urn_ones == (urn_size >> 1)) begin
          equilibrium_at = steps_taken;
        end
        if (recurrence_at == 0 && urn_ones == urn_size) begin
          recurrence_at = steps_taken;
        end
      end
    end else if (it.bin > urn_size) begin
      r.bad_index = 1'b1;
    end else begin
      r.bin_value = occupancy[it.bin];
    end
    r.ones_count       = urn_ones;
    r.step_number      = steps_taken;
    r.equilibrium_step = equilibrium_at;
    r.recurrence_step  = recurrence_at;
    r.finished         = (equilibrium_at != 0) && (recurrence_at != 0);
    return r;
  endfunction

  // random item; while guarded, no flip may land on the half count
  function automatic in_t next_random_item(input bit guarded);
    in_t               it;
    int unsigned       pick;
    int unsigned       start;
    int unsigned       k;
    int unsigned       q;
    logic [ONES_W-1:0] landing;
    it.mode     = MODE_STEP;
    it.particle = 6'($urandom);
    it.bin      = 7'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      it.mode = MODE_READ;
      if ($urandom_range(0, 4) != 0) begin
        it.bin = 7'($urandom_range(0, urn_size));
      end
    end else if (pick < 38) begin
      // out-of-range particle, or bin when every particle is in use
      if (urn_size < PC_MAX) begin
        it.particle = 6'($urandom_range(urn_size, 63));
      end else begin
        it.mode = MODE_READ;
        it.bin  = 7'($urandom_range(65, 127));
      end
    end else begin
      // scan from a random particle; falls back to a read if nothing is allowed
      it.mode = MODE_READ;
      start = $urandom_range(0, urn_size - 1);
      for (k = 0; k < urn_size; k++) begin
        q = (start + k) % urn_size;
        landing = urn_bits[q] ? urn_ones - 7'd1 : urn_ones + 7'd1;
        if (it.mode == MODE_READ && (!guarded || landing != (urn_size >> 1))) begin
          it.mode     = MODE_STEP;
          it.particle = 6'(q);
        end
      end
    end
    return it;
  endfunction

  // offer one transaction on the input channel and record its result
  task automatic offer(input in_t it, input logic fixed, input out_t want);
    out_t predicted;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    predicted = advance_urn(it);
    results_due.push_back(fixed ? want : predicted);
  endtask

  // drain, then write the particle count while the block is idle
  task automatic write_particle_count(input logic [ONES_W-1:0] value);
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    load_particle_count(value);
  endtask

  task automatic compare_field(input string name, input logic [OUT_W-1:0] want,
                               input logic [OUT_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  // receiver: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= 200;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // check each output transaction against the oldest expectation
  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        $error("result transaction with no expectation outstanding");
        fail_count++;
      end else begin
        want = results_due.pop_front();
        compare_field("ones_count", 32'(want.ones_count), 32'(out_data.ones_count));
        compare_field("step_number", want.step_number, out_data.step_number);
        compare_field("equilibrium_step", want.equilibrium_step,
                      out_data.equilibrium_step);
        compare_field("recurrence_step", want.recurrence_step, out_data.recurrence_step);
        compare_field("finished", 32'(want.finished), 32'(out_data.finished));
        compare_field("bin_value", want.bin_value, out_data.bin_value);
        compare_field("bad_index", 32'(want.bad_index), 32'(out_data.bad_index));
      end
    end
  end

  // run limit
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // stimulus
  initial begin
    logic [ONES_W-1:0] plan [9];
    int                i;
    int                r;
    int unsigned       phase;
    int unsigned       n;
    urn_bits       = '1;
    urn_size       = PC_MAX;
    urn_ones       = PC_MAX;
    steps_taken    = '0;
    equilibrium_at = '0;
    recurrence_at  = '0;
    for (i = 0; i <= MAX_PARTICLES_DEF; i++) begin
      occupancy[i] = '0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    tx_idle_pct = 11;
    rx_idle_pct <= 70;

    // directed table; recurrence gets latched early here
    for (r = 0; r < ROWS; r++) begin
      if (DIRECTED[r].kind == ROW_CFG) begin
        write_particle_count(DIRECTED[r].cfg_value);
      end else begin
        offer(DIRECTED[r].item, DIRECTED[r].fixed, DIRECTED[r].want);
      end
    end

    // random phases hold off equilibrium; the last one lets the urn finish
    plan = '{7'd64, 7'd2, 7'($urandom_range(3, 63)), 7'd127, 7'($urandom_range(0, 127)),
             7'd3, 7'd64, 7'($urandom_range(2, 63)), 7'd0};
    for (phase = 0; phase < 10; phase++) begin
      if (phase == 3) begin
        tx_idle_pct = 70;
        rx_idle_pct <= 11;
      end
      if (phase == 6) begin
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
      end
      write_particle_count(phase < 9 ? plan[phase] : 7'd4);
      if (phase == 6) begin
        hold_req <= 1'b1;
      end
      for (n = 0; n < 90; n++) begin
        offer(next_random_item(phase < 9), 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
